// ===== rtl/utf8v_pkg.sv =====
`timescale 1ns / 1ps

package utf8v_pkg;

	localparam int unsigned CpWidth = 21;

	localparam logic [CpWidth-1:0] CpMax       = 21'h10FFFF;
	localparam logic [CpWidth-1:0] CpMin2      = 21'h000080;
	localparam logic [CpWidth-1:0] CpMin3      = 21'h000800;
	localparam logic [CpWidth-1:0] CpMin4      = 21'h010000;
	localparam logic [CpWidth-1:0] SurrLo      = 21'h00D800;
	localparam logic [CpWidth-1:0] SurrHi      = 21'h00DFFF;
	localparam logic [CpWidth-1:0] CtlC0End    = 21'h000020;
	localparam logic [CpWidth-1:0] CtlDelLo    = 21'h00007F;
	localparam logic [CpWidth-1:0] CtlC1Hi     = 21'h00009F;

	localparam logic [7:0] LeadMin2 = 8'hC2;

	localparam logic [2:0] Lead2Tag = 3'b110;
	localparam logic [3:0] Lead3Tag = 4'b1110;
	localparam logic [4:0] Lead4Tag = 5'b11110;
	localparam logic [1:0] ContTag  = 2'b10;

	typedef struct packed {
		logic [1:0]         pending;
		logic [1:0]         seq_len;
		logic [CpWidth-1:0] code_point;
		logic               failed;
	} utf8v_state_t;

	localparam utf8v_state_t StateClear = '{
		pending:    2'd0,
		seq_len:    2'd0,
		code_point: '0,
		failed:     1'b0
	};

	// conts is the number of continuation bytes the sequence had
	function automatic logic point_rejected(input logic [CpWidth-1:0] cp,
			input logic [1:0] conts);
		logic bad;
		bad = 1'b0;
		if (conts == 2'd1 && cp < CpMin2) bad = 1'b1;
		if (conts == 2'd2 && cp < CpMin3) bad = 1'b1;
		if (conts == 2'd3 && cp < CpMin4) bad = 1'b1;
		if (cp > CpMax) bad = 1'b1;
		if (cp inside {[SurrLo:SurrHi]}) bad = 1'b1;
		if (cp < CtlC0End) bad = 1'b1;
		if (cp inside {[CtlDelLo:CtlC1Hi]}) bad = 1'b1;
		return bad;
	endfunction

endpackage

// ===== rtl/utf8v_step.sv =====
`timescale 1ns / 1ps

module utf8v_step import utf8v_pkg::*; (
	input  utf8v_state_t cur,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	input  logic         empty_string,
	output utf8v_state_t nxt,
	output logic         string_ok,
	output logic         verdict_final
);

	utf8v_state_t       upd;
	logic               fail;
	logic [CpWidth-1:0] cp_ext;
	logic [1:0]         pend_dec;

	always_comb begin
		upd      = cur;
		fail     = 1'b0;
		cp_ext   = {cur.code_point[CpWidth-7:0], data_byte[5:0]};
		pend_dec = cur.pending - 2'd1;

		if (!cur.failed) begin
			if (cur.pending == 2'd0) begin
				if (!data_byte[7]) begin
					if (point_rejected({13'd0, data_byte}, 2'd0)) fail = 1'b1;
				end else if (data_byte[7:5] == Lead2Tag) begin
					if (data_byte < LeadMin2) begin
						fail = 1'b1;
					end else begin
						upd.code_point = {16'd0, data_byte[4:0]};
						upd.pending    = 2'd1;
						upd.seq_len    = 2'd1;
					end
				end else if (data_byte[7:4] == Lead3Tag) begin
					upd.code_point = {17'd0, data_byte[3:0]};
					upd.pending    = 2'd2;
					upd.seq_len    = 2'd2;
				end else if (data_byte[7:3] == Lead4Tag) begin
					upd.code_point = {18'd0, data_byte[2:0]};
					upd.pending    = 2'd3;
					upd.seq_len    = 2'd3;
				end else begin
					fail = 1'b1;
				end
			end else begin
				if (data_byte[7:6] != ContTag) begin
					fail = 1'b1;
				end else begin
					upd.code_point = cp_ext;
					upd.pending    = pend_dec;
					if (pend_dec == 2'd0) begin
						if (point_rejected(cp_ext, cur.seq_len)) begin
							fail = 1'b1;
						end else begin
							upd.seq_len    = 2'd0;
							upd.code_point = '0;
						end
					end
				end
			end
		end

		// a sequence still open at the end of the string fails it
		if (last_byte && upd.pending != 2'd0) fail = 1'b1;

		if (fail) begin
			upd        = StateClear;
			upd.failed = 1'b1;
		end

		string_ok     = !upd.failed;
		verdict_final = last_byte;
		nxt           = last_byte ? StateClear : upd;

		if (empty_string) begin
			nxt           = StateClear;
			string_ok     = 1'b1;
			verdict_final = 1'b1;
		end
	end

endmodule

// ===== rtl/utf8_text_validator.sv =====
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------
// in       in_valid / in_stall  data_byte, last_byte, empty_string
// out      out_valid/out_stall  string_ok, verdict_final
//
// One byte per cycle sustained while out_stall stays low.
// Bytes land in an input register; the UTF-8 decode step sits between it
// and the result register and updates the sequence state in the same cycle.
// in_stall rises only when both registers hold items and out_stall is high.
// arst_n clears valid flags and the decode state; payload is not reset.
module utf8_text_validator import utf8v_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       empty_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       string_ok,
	output logic       verdict_final
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         empty_s1;
	logic         valid_s2;
	logic         ok_s2;
	logic         final_s2;
	utf8v_state_t state_q;
	utf8v_state_t state_nxt;
	logic         ok_nxt;
	logic         final_nxt;
	logic         adv_s2;
	logic         take_in;

	assign adv_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s2;
	assign take_in  = in_valid && !in_stall;

	utf8v_step u_step (
		.cur           (state_q),
		.data_byte     (byte_s1),
		.last_byte     (last_s1),
		.empty_string  (empty_s1),
		.nxt           (state_nxt),
		.string_ok     (ok_nxt),
		.verdict_final (final_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= StateClear;
		end else begin
			if (take_in) valid_s1 <= 1'b1;
			else if (adv_s2) valid_s1 <= 1'b0;
			if (adv_s2) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1  <= data_byte;
			last_s1  <= last_byte;
			empty_s1 <= empty_string;
		end
		if (adv_s2) begin
			ok_s2    <= ok_nxt;
			final_s2 <= final_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign string_ok     = ok_s2;
	assign verdict_final = final_s2;

endmodule

// ===== rtl/utf8v_checker.sv =====
`timescale 1ns / 1ps

module utf8v_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       string_ok,
	input logic       verdict_final
);

	logic       in_acc;
	logic       out_acc;
	logic [2:0] inflight_q;
	logic       bad_seen_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
			bad_seen_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + {2'd0, in_acc} - {2'd0, out_acc};
			// a failed, unfinished string stays failed until its last item
			if (out_acc) bad_seen_q <= !string_ok && !verdict_final;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(string_ok)
			&& $stable(verdict_final))
		else $error("result changed while stalled");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd2 && (!out_valid || inflight_q != 3'd0))
		else $error("item count out of range");

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_seen_q && !verdict_final |-> !string_ok)
		else $error("failed string recovered before its end");

endmodule

bind utf8_text_validator utf8v_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.string_ok     (string_ok),
	.verdict_final (verdict_final)
);

// ===== sim/utf8_text_validator_tb.sv =====
`timescale 1ns / 1ps

module utf8_text_validator_tb;

	localparam int CycleLimit  = 200000;
	localparam int TargetItems = 1650;

	localparam logic [20:0] EdgePoints [10] = '{
		21'h20, 21'h7E, 21'hA0, 21'h7FF, 21'h800,
		21'hD7FF, 21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF
	};

	typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_t;

	typedef struct {
		logic ok;
		logic fin;
	} verdict_t;

	class utf8_verdict_board;
		logic [1:0]  pending;
		logic [1:0]  seq_len;
		logic [20:0] cp;
		logic        failed;
		verdict_t    verdicts_due[$];
		int          errors = 0;
		int          checked = 0;
		int          strings_ok = 0;
		int          strings_bad = 0;

		function new();
			clear();
		endfunction

		function void clear();
			pending = 2'd0;
			seq_len = 2'd0;
			cp      = 21'd0;
			failed  = 1'b0;
		endfunction

		function void abort_sequence();
			failed  = 1'b1;
			pending = 2'd0;
			seq_len = 2'd0;
			cp      = 21'd0;
		endfunction

		// conts: continuation bytes the sequence carried
		function logic point_illegal(logic [20:0] p, logic [1:0] conts);
			return (conts == 2'd1 && p < 21'h80) || (conts == 2'd2 && p < 21'h800) ||
				(conts == 2'd3 && p < 21'h10000) || p > 21'h10FFFF ||
				(p >= 21'hD800 && p <= 21'hDFFF) || p < 21'h20 ||
				(p >= 21'h7F && p <= 21'h9F);
		endfunction

		function void note_input(logic [7:0] b, logic last, logic empty);
			verdict_t v;
			if (empty) begin
				clear();
				v.ok  = 1'b1;
				v.fin = 1'b1;
				verdicts_due.insert(verdicts_due.size(), v);
				strings_ok++;
				return;
			end
			if (!failed) begin
				if (pending == 2'd0) begin
					if (b[7] == 1'b0) begin
						if (point_illegal({13'd0, b}, 2'd0))
							abort_sequence();
					end else if (b[7:5] == 3'b110) begin
						if (b < 8'hC2) begin
							abort_sequence();
						end else begin
							cp      = {16'd0, b[4:0]};
							pending = 2'd1;
							seq_len = 2'd1;
						end
					end else if (b[7:4] == 4'b1110) begin
						cp      = {17'd0, b[3:0]};
						pending = 2'd2;
						seq_len = 2'd2;
					end else if (b[7:3] == 5'b11110) begin
						cp      = {18'd0, b[2:0]};
						pending = 2'd3;
						seq_len = 2'd3;
					end else begin
						abort_sequence();
					end
				end else if (b[7:6] != 2'b10) begin
					abort_sequence();
				end else begin
					cp      = {cp[14:0], b[5:0]};
					pending = pending - 2'd1;
					if (pending == 2'd0) begin
						if (point_illegal(cp, seq_len)) begin
							abort_sequence();
						end else begin
							seq_len = 2'd0;
							cp      = 21'd0;
						end
					end
				end
			end
			if (last && pending != 2'd0)
				abort_sequence();
			v.ok  = !failed;
			v.fin = last;
			verdicts_due.insert(verdicts_due.size(), v);
			if (last) begin
				if (failed)
					strings_bad++;
				else
					strings_ok++;
				clear();
			end
		endfunction

		function void check_result(logic ok, logic fin);
			verdict_t v;
			if (verdicts_due.size() == 0) begin
				$error("result with no item outstanding: string_ok %0b verdict_final %0b",
					ok, fin);
				errors++;
				return;
			end
			v = verdicts_due.pop_front();
			checked++;
			if (ok !== v.ok) begin
				$error("string_ok: expected %0b, got %0b", v.ok, ok);
				errors++;
			end
			if (fin !== v.fin) begin
				$error("verdict_final: expected %0b, got %0b", v.fin, fin);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'd0;
	logic       last_byte = 1'b0;
	logic       empty_string = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       string_ok;
	logic       verdict_final;

	utf8_verdict_board board;
	logic [7:0]        text[$];
	int                burst_left = 5;
	int                items_sent = 0;
	int                stall_cycles = 0;
	int                cycle_count = 0;

	utf8_text_validator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.empty_string  (empty_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.string_ok     (string_ok),
		.verdict_final (verdict_final)
	);

	always #2 clk = ~clk;

	// Offer one item and hold it until taken; close the burst with a gap when due.
	task automatic send_item(input logic [7:0] b, input logic last, input logic empty);
		in_valid     <= 1'b1;
		data_byte    <= b;
		last_byte    <= last;
		empty_string <= empty;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_input(b, last, empty);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4))
				@(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
	endtask

	// cut >= 0 replaces byte number cut with an empty item and drops the rest
	task automatic send_text(input int cut);
		for (int i = 0; i < text.size(); i++) begin
			if (i == cut) begin
				send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
				return;
			end
			send_item(text[i], i == text.size() - 1, 1'b0);
		end
	endtask

	function automatic void add_byte(input logic [7:0] b);
		text.insert(text.size(), b);
	endfunction

	// n = 0 picks the shortest form; a longer n gives an overlong encoding
	function automatic void put_point(input logic [20:0] p, input int n);
		if (n == 0)
			n = (p < 21'h80) ? 1 : (p < 21'h800) ? 2 : (p < 21'h10000) ? 3 : 4;
		case (n)
			1: add_byte(p[7:0]);
			2: begin
				add_byte({3'b110, p[10:6]});
				add_byte({2'b10, p[5:0]});
			end
			3: begin
				add_byte({4'b1110, p[15:12]});
				add_byte({2'b10, p[11:6]});
				add_byte({2'b10, p[5:0]});
			end
			default: begin
				add_byte({5'b11110, p[20:18]});
				add_byte({2'b10, p[17:12]});
				add_byte({2'b10, p[11:6]});
				add_byte({2'b10, p[5:0]});
			end
		endcase
	endfunction

	function automatic void put_legal_char();
		logic [20:0] p;
		case ($urandom_range(0, 4))
			0: put_point(21'($urandom_range(21'h20, 21'h7E)), 1);
			1: put_point(21'($urandom_range(21'hA0, 21'h7FF)), 2);
			2: begin
				p = 21'($urandom_range(21'h800, 21'hFFFF));
				if (p >= 21'hD800 && p <= 21'hDFFF)
					p = p - 21'h800;
				put_point(p, 3);
			end
			3: put_point(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
			default: put_point(EdgePoints[$urandom_range(0, 9)], 0);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result(string_ok, verdict_final);
			if (in_valid && in_stall)
				stall_cycles++;
		end
	end

	// generous bound on a slow but correct run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("utf8_text_validator_tb NOT OK");
			$finish;
		end
	end

	initial begin : stall_gen
		stall_mode_t mode;
		int          len;
		int          next_hold;
		next_hold = 300;
		@(posedge arst_n);
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			len  = $urandom_range(10, 150);
			repeat (len) begin
				@(posedge clk);
				case (mode)
					StallNone:  out_stall <= 1'b0;
					StallLight: out_stall <= ($urandom_range(0, 3) == 0);
					StallHeavy: out_stall <= ($urandom_range(0, 1) == 1);
					default:    out_stall <= (cycle_count % 5 < 2);
				endcase
			end
			// long hold-off so both stages fill and the input backs up
			if (board.checked >= next_hold) begin
				@(posedge clk);
				out_stall <= 1'b1;
				repeat (100)
					@(posedge clk);
				next_hold += 500;
			end
		end
	end

	initial begin : stimulus
		int          kind;
		int          len;
		int          n;
		logic [20:0] p;
		board = new();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		send_item(8'hA5, 1'b1, 1'b1);
		text = '{8'h00};
		send_text(-1);
		text = '{8'h7F};
		send_text(-1);
		// rejected lead, following byte ignored
		text = '{8'hC0, 8'h41};
		send_text(-1);
		text = '{8'hFF};
		send_text(-1);
		// stray continuation
		text = '{8'h80};
		send_text(-1);
		text = '{8'hC2, 8'hA0};
		send_text(-1);
		// overlong three-byte form
		text = '{8'hE0, 8'h9F, 8'hBF};
		send_text(-1);
		// surrogate
		text = '{8'hED, 8'hA0, 8'h80};
		send_text(-1);
		text = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_text(-1);
		text = '{8'hF4, 8'h90, 8'h80, 8'h80};
		send_text(-1);
		// sequence cut short by the last byte
		text = '{8'hE2, 8'h82};
		send_text(-1);
		// empty item arriving mid-sequence
		text = '{8'hC3, 8'hA9};
		send_text(1);

		while (items_sent < TargetItems) begin
			text.delete();
			kind = $urandom_range(0, 99);
			len  = $urandom_range(1, 10);
			if (kind >= 92 && kind < 97) begin
				send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
				continue;
			end
			if (kind >= 85 && kind < 92) begin
				repeat (len)
					add_byte(8'($urandom_range(0, 255)));
			end else if (kind >= 60 && kind < 75) begin
				repeat ($urandom_range(0, 3))
					put_legal_char();
				case ($urandom_range(0, 5))
					0: put_point(21'($urandom_range(0, 31)), 0);
					1: put_point(21'($urandom_range(127, 159)), 0);
					2: put_point(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
					3: begin
						n = $urandom_range(2, 4);
						p = 21'($urandom_range(0,
							(n == 2) ? 21'h7F : (n == 3) ? 21'h7FF : 21'hFFFF));
						put_point(p, n);
					end
					4: put_point(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
					default: add_byte(8'(($urandom_range(0, 1) == 1) ?
						$urandom_range(8'h80, 8'hBF) : $urandom_range(8'hF8, 8'hFF)));
				endcase
				repeat ($urandom_range(0, 3))
					put_legal_char();
			end else begin
				repeat (len)
					put_legal_char();
				if (kind >= 75 && kind < 85) begin
					if ($urandom_range(0, 1) == 1)
						text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
					else if (text.size() > 1)
						void'(text.pop_back());
				end
			end
			send_text((kind >= 97) ? $urandom_range(0, text.size() - 1) : -1);
		end
		in_valid <= 1'b0;

		while (board.verdicts_due.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		$display("%0d items sent, %0d verdicts checked: %0d strings accepted, %0d rejected",
			items_sent, board.checked, board.strings_ok, board.strings_bad);
		$display("input backpressure seen on %0d cycles", stall_cycles);
		if (board.errors == 0)
			$display("utf8_text_validator_tb OK");
		else
			$display("utf8_text_validator_tb NOT OK");
		$finish;
	end

endmodule
